/* hw/rtl/ple_pkg.sv */
// shared constants, types and codes of the positional list engine
package ple_pkg;

  localparam int CAPACITY      = 32;
  localparam int ELEMENT_WIDTH = 32;

  // index into the element store, and a count that can reach CAPACITY
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  // widths of the port fields
  localparam int KIND_W   = 3;
  localparam int POS_W    = 6;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  // common width for position / count compares (count is at most 6 bits)
  localparam int CMP_W = 8;

  typedef enum logic [KIND_W-1:0] {
    K_ADD_FRONT  = 3'd0,
    K_ADD_REAR   = 3'd1,
    K_REM_FRONT  = 3'd2,
    K_REM_REAR   = 3'd3,
    K_REM_AT     = 3'd4,
    K_INS_BEFORE = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_INS  = 2'd1,
    OP_REM  = 2'd2
  } op_t;

  // what one command will do to the store
  typedef struct packed {
    op_t             op;
    status_t         status;
    logic [AW-1:0]   idx;
    logic [CW-1:0]   moves;
  } plan_t;

endpackage

/* hw/rtl/positional_list_engine_top.sv */
// top level: command port, shift sequencer and element store of the list engine
//
// Positional list engine. Holds an ordered list of up to CAPACITY elements in
// one ram with a registered read. A command is taken when start is
// high and busy is low; exactly one result per command appears on the out_
// ports for a single cycle, flagged by out_valid, and must be captured then,
// since the block cannot be held off. Commands that change nothing (any failed
// check) answer in the next cycle and never raise busy. An insert or remove
// shifts the entries between its position and the rear one per cycle through
// the ram's read and write ports: m = count - index entries move (up to
// CAPACITY), none for an insert at the rear, and the result shows in the
// cycle busy falls, when the next command may already be taken. The store
// powers up undefined and needs no clearing; only entries below the count
// are ever read.
module positional_list_engine_top import ple_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // command side
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [POS_W-1:0]    in_position,
  input  logic [VALUE_W-1:0]  in_new_value,
  // result side
  output logic                out_valid,
  output logic [VALUE_W-1:0]  out_removed_value,
  output logic [STATUS_W-1:0] out_status,
  output logic [COUNT_W-1:0]  out_count_after,
  output logic                out_is_empty
);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SHIFT  = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  op_t                      op_r, op_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic [ELEMENT_WIDTH-1:0] val_r, val_nxt;
  logic [AW-1:0]            src_r, src_nxt;       // next entry to read
  logic [CW-1:0]            left_r, left_nxt;     // reads still to issue
  logic                     fly_r, fly_nxt;       // read data arrives this cycle
  logic [AW-1:0]            fly_dst_r, fly_dst_nxt;
  logic                     fly_first_r, fly_first_nxt;
  logic                     first_r, first_nxt;   // first read of a remove
  logic [ELEMENT_WIDTH-1:0] removed_r, removed_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]       out_removed_r, out_removed_nxt;
  status_t                  out_status_r, out_status_nxt;
  logic [CW-1:0]            out_count_r, out_count_nxt;

  plan_t                    plan;
  logic                     accept;
  logic [CW-1:0]            cnt_m1;
  logic [63:0]              new_wide;
  logic [63:0]              rem_wide;

  // ram ports
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [ELEMENT_WIDTH-1:0] wr_data;
  logic                     rd_en;
  logic [ELEMENT_WIDTH-1:0] rd_data;

  ple_decode u_decode (
    .kind     (in_kind),
    .position (in_position),
    .count    (count_r),
    .plan     (plan)
  );

  ple_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (src_r),
    .rd_data (rd_data)
  );

  assign accept   = start && (state_r == S_IDLE);
  assign cnt_m1   = count_r - CW'(1);
  // element width may be narrower or wider than the 32-bit ports
  assign new_wide = 64'(in_new_value);
  assign rem_wide = 64'(removed_r);

  // one read per shift cycle while reads remain; its data is written one entry over in the cycle after
  assign rd_en = (state_r == S_SHIFT) && (left_r != '0);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fly_dst_r;
    wr_data = rd_data;
    if (state_r == S_SHIFT && fly_r && !fly_first_r) begin
      wr_en = 1'b1;
    end else if (state_r == S_FINISH && op_r == OP_INS) begin
      // new element lands in the gap opened by the shift
      wr_en   = 1'b1;
      wr_addr = idx_r;
      wr_data = val_r;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    op_nxt          = op_r;
    idx_nxt         = idx_r;
    val_nxt         = val_r;
    src_nxt         = src_r;
    left_nxt        = left_r;
    fly_nxt         = 1'b0;
    fly_dst_nxt     = fly_dst_r;
    fly_first_nxt   = 1'b0;
    first_nxt       = first_r;
    removed_nxt     = removed_r;
    out_valid_nxt   = 1'b0;
    out_removed_nxt = out_removed_r;
    out_status_nxt  = out_status_r;
    out_count_nxt   = out_count_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (plan.op == OP_NONE) begin
            // rejected command: answer at once, list untouched
            out_valid_nxt   = 1'b1;
            out_removed_nxt = '0;
            out_status_nxt  = plan.status;
            out_count_nxt   = count_r;
          end else begin
            op_nxt    = plan.op;
            idx_nxt   = plan.idx;
            val_nxt   = new_wide[ELEMENT_WIDTH-1:0];
            left_nxt  = plan.moves;
            first_nxt = (plan.op == OP_REM);
            // insert walks down from the rear, remove walks up from idx
            src_nxt   = (plan.op == OP_INS) ? cnt_m1[AW-1:0] : plan.idx;
            state_nxt = (plan.moves == '0) ? S_FINISH : S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (fly_r && fly_first_r) begin
          removed_nxt = rd_data;
        end
        if (rd_en) begin
          fly_nxt       = 1'b1;
          fly_first_nxt = first_r;
          first_nxt     = 1'b0;
          fly_dst_nxt   = (op_r == OP_INS) ? src_r + AW'(1) : src_r - AW'(1);
          src_nxt       = (op_r == OP_INS) ? src_r - AW'(1) : src_r + AW'(1);
          left_nxt      = left_r - CW'(1);
        end else if (!fly_r) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        out_valid_nxt   = 1'b1;
        out_status_nxt  = ST_OK;
        if (op_r == OP_INS) begin
          count_nxt       = count_r + CW'(1);
          out_removed_nxt = '0;
        end else begin
          count_nxt       = cnt_m1;
          out_removed_nxt = rem_wide[VALUE_W-1:0];
        end
        out_count_nxt = count_nxt;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      fly_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      fly_r       <= fly_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and bookkeeping, no reset needed
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    idx_r         <= idx_nxt;
    val_r         <= val_nxt;
    src_r         <= src_nxt;
    left_r        <= left_nxt;
    fly_dst_r     <= fly_dst_nxt;
    fly_first_r   <= fly_first_nxt;
    first_r       <= first_nxt;
    removed_r     <= removed_nxt;
    out_removed_r <= out_removed_nxt;
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_removed_value = out_removed_r;
  assign out_status        = out_status_r;
  // count never wraps: it reaches at most CAPACITY (32), which fits the 6-bit port
  assign out_count_after   = COUNT_W'(out_count_r);
  assign out_is_empty      = (out_count_r == '0);

endmodule

/* hw/rtl/ple_ram.sv */
// generic single-port-write, registered-read ram
module ple_ram #(
  parameter  int WIDTH  = 32,
  parameter  int DEPTH  = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/ple_decode.sv */
// command check against the current count and shift plan
module ple_decode import ple_pkg::*; (
  input  logic [KIND_W-1:0] kind,
  input  logic [POS_W-1:0]  position,
  input  logic [CW-1:0]     count,
  output plan_t             plan
);

  logic [CMP_W-1:0] pos_w;
  logic [CMP_W-1:0] cnt_w;
  logic [CMP_W-1:0] pos_m1;
  logic [CW-1:0]    cnt_m1;
  logic             full;
  logic             empty;

  assign pos_w  = CMP_W'(position);
  assign cnt_w  = CMP_W'(count);
  assign pos_m1 = pos_w - CMP_W'(1);
  assign cnt_m1 = count - CW'(1);
  assign full   = (count == CW'(CAPACITY));
  assign empty  = (count == '0);

  always_comb begin
    plan.op     = OP_NONE;
    plan.status = ST_OK;
    plan.idx    = '0;
    case (kind_t'(kind))
      K_ADD_FRONT: begin
        if (full) plan.status = ST_FULL;
        else plan.op = OP_INS;
      end
      K_ADD_REAR: begin
        if (full) plan.status = ST_FULL;
        else begin
          plan.op  = OP_INS;
          plan.idx = count[AW-1:0];
        end
      end
      K_REM_FRONT: begin
        if (empty) plan.status = ST_UNDERFLOW;
        else plan.op = OP_REM;
      end
      K_REM_REAR: begin
        if (empty) plan.status = ST_UNDERFLOW;
        else begin
          plan.op  = OP_REM;
          plan.idx = cnt_m1[AW-1:0];
        end
      end
      K_REM_AT: begin
        if (pos_w == '0 || pos_w > cnt_w) plan.status = ST_RANGE;
        else begin
          plan.op  = OP_REM;
          plan.idx = pos_m1[AW-1:0];
        end
      end
      K_INS_BEFORE: begin
        if (pos_w == '0 || pos_w > cnt_w + CMP_W'(1)) plan.status = ST_RANGE;
        else if (empty) plan.status = ST_UNDERFLOW;
        else if (full) plan.status = ST_FULL;
        else begin
          plan.op  = OP_INS;
          plan.idx = pos_m1[AW-1:0];
        end
      end
      default: plan.status = ST_RANGE;
    endcase
    // entries that move: from idx up to the rear
    plan.moves = count - CW'(plan.idx);
  end

endmodule
